// ===== hw/rtl/ctd_pkg.sv =====
// Shared types and constants for the cube map texel direction block.
// Holds the face decode table and the fixed field widths.
// No dependencies.
package ctd_pkg;

    localparam int FACE_W = 3;
    localparam int TEX_W  = 12;
    localparam int CFG_W  = 13;
    localparam int DIR_W  = 16;

    localparam logic [CFG_W-1:0] FACE_SIZE_RST = 13'd256;

    // saturation limits of a signed DIR_W result
    localparam int POS_LIM = (1 << (DIR_W - 1)) - 1;
    localparam int NEG_LIM = (1 << (DIR_W - 1));

    // face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // which term feeds a component: a, b, s or zero
    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_S,
        SRC_Z
    } t_src;

    typedef struct packed {
        t_src src;
        logic flip;
    } t_comp;

    typedef struct packed {
        t_comp cx;
        t_comp cy;
        t_comp cz;
        logic  ok;
    } t_face_map;

    // face to signed axis assignment
    function automatic t_face_map face_map(input logic [FACE_W-1:0] f);
        t_face_map m;
        unique case (f)
            FACE_PX: m = '{'{SRC_S, 1'b0}, '{SRC_B, 1'b1}, '{SRC_A, 1'b1}, 1'b1};
            FACE_NX: m = '{'{SRC_S, 1'b1}, '{SRC_B, 1'b1}, '{SRC_A, 1'b0}, 1'b1};
            FACE_PY: m = '{'{SRC_A, 1'b0}, '{SRC_S, 1'b0}, '{SRC_B, 1'b0}, 1'b1};
            FACE_NY: m = '{'{SRC_A, 1'b0}, '{SRC_S, 1'b1}, '{SRC_B, 1'b1}, 1'b1};
            FACE_PZ: m = '{'{SRC_A, 1'b0}, '{SRC_B, 1'b1}, '{SRC_S, 1'b0}, 1'b1};
            FACE_NZ: m = '{'{SRC_A, 1'b1}, '{SRC_B, 1'b1}, '{SRC_S, 1'b1}, 1'b1};
            default: m = '{'{SRC_Z, 1'b0}, '{SRC_Z, 1'b0}, '{SRC_Z, 1'b0}, 1'b0};
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/ctd_if.sv =====
// Valid/ready channel interfaces for the cube map texel direction block.
// Depends on ctd_pkg for field widths.
interface ctd_in_if import ctd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FACE_W-1:0] face;
    logic [TEX_W-1:0]  texel_x;
    logic [TEX_W-1:0]  texel_y;

    modport source(output valid, face, texel_x, texel_y, input ready);
    modport sink(input valid, face, texel_x, texel_y, output ready);
endinterface

interface ctd_out_if import ctd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    face_ok;

    modport source(output valid, dir_x, dir_y, dir_z, face_ok, input ready);
    modport sink(input valid, dir_x, dir_y, dir_z, face_ok, output ready);
endinterface

// ===== hw/rtl/cubemap_texel_direction.sv =====
// Cube map texel to unit direction vector, fully pipelined.
//
// Input channel i_in carries one beat per texel: face index and texel column
// and row. Output channel o_out carries one beat per input beat, in order:
// the normalized direction in signed Q1.15 (Q(16-F).F in general) and a
// face_ok flag. Faces six and seven give a zero vector with face_ok low.
// The face edge length is written through i_cfg_we / i_cfg_data while idle;
// zero acts as one and values above MAX_FACE_SIZE clamp to it.
//
// Throughput: one beat per cycle while the output is not stalled. Each of
// the three component lanes holds a bit-per-stage divide and square root,
// behind three setup stages.
//
// Reset clears all stage valid bits and sets the face size to 256.
// When the receiver stalls with a beat waiting, the whole pipeline holds
// and i_in.ready drops; no beat is lost or repeated. With the output empty
// the pipeline keeps moving and bubbles fill in.
module cubemap_texel_direction import ctd_pkg::*; #(
    parameter int MAX_FACE_SIZE = 4096,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    ctd_in_if.sink           i_in,
    ctd_out_if.source        o_out
);

    localparam int SW       = $clog2(MAX_FACE_SIZE) + 1;
    localparam int MW       = (SW > 13) ? SW : 13;
    localparam int NW       = 2 * MW + 2;
    localparam int F        = OUT_FRAC_BITS;
    localparam int LANE_LAT = (2 * F + 2) + (F + 2) + 2;
    localparam int PIPE     = 3 + LANE_LAT;

    logic [CFG_W-1:0] r_face_size;
    logic             r_vld[0:PIPE-1];
    logic             r_ok [0:PIPE-1];
    logic             w_en;

    // face size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FACE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_face_size <= i_cfg_data;
        end
    end

    // global advance: move unless a finished beat is stuck at the output
    assign w_en       = !r_vld[PIPE-1] || o_out.ready;
    assign i_in.ready = w_en;

    // stage 0: clamp size, offsets a and b, face decode
    t_face_map n_map;
    int        n_s;
    int        n_a;
    int        n_b;
    always_comb begin
        n_map = face_map(i_in.face);
        if (r_face_size == '0) begin
            n_s = 1;
        end else if (int'(r_face_size) > MAX_FACE_SIZE) begin
            n_s = MAX_FACE_SIZE;
        end else begin
            n_s = int'(r_face_size);
        end
        n_a = 2 * int'(i_in.texel_x) + 1 - n_s;
        n_b = 2 * int'(i_in.texel_y) + 1 - n_s;
    end

    // valid and face_ok travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < PIPE; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok[0] <= n_map.ok;
            for (int k = 1; k < PIPE; k++) begin
                r_ok[k] <= r_ok[k-1];
            end
        end
    end

    logic [MW-1:0] r0_amag, r0_bmag, r0_smag;
    logic          r0_aneg, r0_bneg;
    t_face_map     r0_map;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_amag <= MW'((n_a < 0) ? -n_a : n_a);
            r0_bmag <= MW'((n_b < 0) ? -n_b : n_b);
            r0_smag <= MW'(n_s);
            r0_aneg <= n_a < 0;
            r0_bneg <= n_b < 0;
            r0_map  <= n_map;
        end
    end

    // stage 1: squares and component signs
    function automatic logic comp_neg(input t_comp c, input logic an, input logic bn);
        logic neg;
        case (c.src)
            SRC_A:   neg = an ^ c.flip;
            SRC_B:   neg = bn ^ c.flip;
            default: neg = c.flip;
        endcase
        return neg;
    endfunction

    logic [2*MW-1:0] r1_a2, r1_b2, r1_s2;
    t_src            r1_srcx, r1_srcy, r1_srcz;
    logic            r1_negx, r1_negy, r1_negz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a2   <= r0_amag * r0_amag;
            r1_b2   <= r0_bmag * r0_bmag;
            r1_s2   <= r0_smag * r0_smag;
            r1_srcx <= r0_map.cx.src;
            r1_srcy <= r0_map.cy.src;
            r1_srcz <= r0_map.cz.src;
            r1_negx <= comp_neg(r0_map.cx, r0_aneg, r0_bneg);
            r1_negy <= comp_neg(r0_map.cy, r0_aneg, r0_bneg);
            r1_negz <= comp_neg(r0_map.cz, r0_aneg, r0_bneg);
        end
    end

    // stage 2: norm squared and per-component c^2
    function automatic logic [2*MW-1:0] pick_sq(input t_src src, input logic [2*MW-1:0] a2,
                                                input logic [2*MW-1:0] b2,
                                                input logic [2*MW-1:0] s2);
        logic [2*MW-1:0] v;
        unique case (src)
            SRC_A:   v = a2;
            SRC_B:   v = b2;
            SRC_S:   v = s2;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [NW-1:0]   r2_n;
    logic [2*MW-1:0] r2_c2x, r2_c2y, r2_c2z;
    logic            r2_negx, r2_negy, r2_negz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_n    <= NW'(r1_a2) + NW'(r1_b2) + NW'(r1_s2);
            r2_c2x  <= pick_sq(r1_srcx, r1_a2, r1_b2, r1_s2);
            r2_c2y  <= pick_sq(r1_srcy, r1_a2, r1_b2, r1_s2);
            r2_c2z  <= pick_sq(r1_srcz, r1_a2, r1_b2, r1_s2);
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;
            r2_negz <= r1_negz;
        end
    end

    // three normalization lanes
    ctd_lane #(.MW(MW), .F(F)) u_lane_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c2  (r2_c2x),
        .i_n   (r2_n),
        .i_neg (r2_negx),
        .o_dir (o_out.dir_x)
    );

    ctd_lane #(.MW(MW), .F(F)) u_lane_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c2  (r2_c2y),
        .i_n   (r2_n),
        .i_neg (r2_negy),
        .o_dir (o_out.dir_y)
    );

    ctd_lane #(.MW(MW), .F(F)) u_lane_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c2  (r2_c2z),
        .i_n   (r2_n),
        .i_neg (r2_negz),
        .o_dir (o_out.dir_z)
    );

    assign o_out.valid   = r_vld[PIPE-1];
    assign o_out.face_ok = r_ok[PIPE-1];

    // bad face beats carry a zero vector
    a_bad_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.face_ok |->
            o_out.dir_x == '0 && o_out.dir_y == '0 && o_out.dir_z == '0)
        else $error("bad face beat with nonzero vector");

    // a good face always has a dominant nonzero component
    a_good_face_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.face_ok |->
            o_out.dir_x != '0 || o_out.dir_y != '0 || o_out.dir_z != '0)
        else $error("good face beat with zero vector");

    // clamped face size stays in range
    a_size_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r0_smag != '0 && int'(r0_smag) <= MAX_FACE_SIZE)
        else $error("face size out of clamp range");

endmodule

// ===== hw/rtl/ctd_lane.sv =====
// One normalization lane: round(c * 2^F / sqrt(N)) with sign and saturation.
// Pipelined restoring divide of c^2 * 2^(2F+2) by N, then a pipelined integer
// square root, one bit per stage. Depends on ctd_pkg.
module ctd_lane import ctd_pkg::*; #(
    parameter int MW = 13,
    parameter int F  = 15
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*MW-1:0]         i_c2,
    input  logic [2*MW+1:0]         i_n,
    input  logic                    i_neg,
    output logic signed [DIR_W-1:0] o_dir
);

    localparam int NW = 2 * MW + 2;   // width of N and of the remainder
    localparam int D  = 2 * F + 2;    // fraction steps of the divide
    localparam int QB = D + 1;        // quotient bits
    localparam int TW = F + 2;        // root bits
    localparam int RW = TW + 2;       // root remainder bits

    logic [NW-1:0] r_rem [0:D];
    logic [QB-1:0] r_q   [0:D];
    logic [NW-1:0] r_n   [0:D];
    logic          r_dneg[0:D];

    logic [TW-1:0]   r_rt  [1:TW];
    logic [RW-1:0]   r_sr  [1:TW];
    logic [2*TW-1:0] r_qq  [1:TW];
    logic            r_sneg[1:TW];

    logic signed [DIR_W-1:0] r_dir;

    // divide: integer bit
    logic [NW-1:0] n_c2w;
    logic          n_ge0;
    always_comb begin
        n_c2w = {2'b00, i_c2};
        n_ge0 = n_c2w >= i_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_ge0 ? n_c2w - i_n : n_c2w;
            r_q[0]    <= {{(QB-1){1'b0}}, n_ge0};
            r_n[0]    <= i_n;
            r_dneg[0] <= i_neg;
        end
    end

    // divide: one fraction bit per stage
    for (genvar k = 1; k <= D; k++) begin : g_div
        logic [NW:0] n_sh;
        logic        n_ge;
        always_comb begin
            n_sh = {r_rem[k-1], 1'b0};
            n_ge = n_sh >= {1'b0, r_n[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? NW'(n_sh - {1'b0, r_n[k-1]}) : NW'(n_sh);
                r_q[k]    <= {r_q[k-1][QB-2:0], n_ge};
                r_n[k]    <= r_n[k-1];
                r_dneg[k] <= r_dneg[k-1];
            end
        end
    end

    // square root: one root bit per stage, two quotient bits consumed
    for (genvar j = 1; j <= TW; j++) begin : g_sqrt
        logic [TW-1:0]   n_rt_in;
        logic [RW-1:0]   n_sr_in;
        logic [2*TW-1:0] n_qq_in;
        logic            n_neg_in;
        logic [RW-1:0]   n_cat;
        logic [RW-1:0]   n_trial;
        logic            n_ge;

        if (j == 1) begin : g_first
            always_comb begin
                n_rt_in  = '0;
                n_sr_in  = '0;
                n_qq_in  = {{(2*TW-QB){1'b0}}, r_q[D]};
                n_neg_in = r_dneg[D];
            end
        end else begin : g_next
            always_comb begin
                n_rt_in  = r_rt[j-1];
                n_sr_in  = r_sr[j-1];
                n_qq_in  = r_qq[j-1];
                n_neg_in = r_sneg[j-1];
            end
        end

        always_comb begin
            n_cat   = {n_sr_in[RW-3:0], n_qq_in[2*TW-1-2*(j-1) -: 2]};
            n_trial = {n_rt_in, 2'b01};
            n_ge    = n_cat >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr[j]   <= n_ge ? n_cat - n_trial : n_cat;
                r_rt[j]   <= {n_rt_in[TW-2:0], n_ge};
                r_qq[j]   <= n_qq_in;
                r_sneg[j] <= n_neg_in;
            end
        end
    end

    // round half up on the odd root, then sign and saturate
    logic [TW:0]  n_rnd;
    int           n_mag;
    int           n_val;
    always_comb begin
        n_rnd = {1'b0, r_rt[TW]} + (TW+1)'(1);
        n_mag = int'(n_rnd[TW:1]);
        if (r_sneg[TW]) begin
            n_val = (n_mag > NEG_LIM) ? -NEG_LIM : -n_mag;
        end else begin
            n_val = (n_mag > POS_LIM) ? POS_LIM : n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dir <= DIR_W'(n_val);
        end
    end

    assign o_dir = r_dir;

endmodule
